[hw/rtl/grid_step_sequencer_unit_defines.svh]
// ----------------------------------------------------------------------------
// grid step sequencer assertion macros
// shared concurrent assertion forms used at the end of the top level
// ----------------------------------------------------------------------------
`ifndef GRID_STEP_SEQUENCER_UNIT_DEFINES_SVH
`define GRID_STEP_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define GSS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define GSS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/gss_pkg.sv]
// ----------------------------------------------------------------------------
// gss_pkg
// types, codes and sizes shared by the grid step sequencer modules
// ----------------------------------------------------------------------------
package gss_pkg;

    // grid geometry
    localparam int NUM_STEPS = 16;
    localparam int NUM_ROWS  = 64;
    localparam int STEP_W    = $clog2(NUM_STEPS);
    localparam int ROW_W     = $clog2(NUM_ROWS);

    // fixed field widths
    localparam int FRAME_W    = 32;
    localparam int FPS_W      = 24;
    localparam int FRAC_W     = 8;
    localparam int STEP_IDX_W = 4;
    localparam int NOTE_W     = 7;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 16;

    // divider sizes: dividend is frame count with the fraction bits appended
    localparam int DIV_W     = FRAME_W + FRAC_W;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    localparam logic [FPS_W-1:0]  FPS_RESET = FPS_W'(1316571);
    localparam logic [NOTE_W-1:0] NOTE_BASE = NOTE_W'(28);

    // page limits
    localparam logic [2:0] PAGE_V_MAX = 3'd7;
    localparam logic       PAGE_H_MAX = 1'b1;

    // page button numbers
    localparam logic [2:0] PAGE_BTN_VINC = 3'd0;
    localparam logic [2:0] PAGE_BTN_VDEC = 3'd1;
    localparam logic [2:0] PAGE_BTN_HDEC = 3'd2;
    localparam logic [2:0] PAGE_BTN_HINC = 3'd3;

    // register file
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-3:0] REG_FPS = '0;

    typedef enum logic [1:0] {
        REQ_TICK = 2'd0,
        REQ_POS  = 2'd1,
        REQ_GRID = 2'd2,
        REQ_PAGE = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        KIND_NOTE = 2'd0,
        KIND_STEP = 2'd1,
        KIND_CELL = 2'd2,
        KIND_PAGE = 2'd3
    } out_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_LOAD,
        ST_SCAN,
        ST_TOGGLE,
        ST_EMIT
    } state_t;

    // divider status back to the sequencer
    typedef struct packed {
        logic              done;
        logic [STEP_W-1:0] quo;
    } div_stat_t;

endpackage

[hw/rtl/gss_ram.sv]
// ----------------------------------------------------------------------------
// gss_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module gss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/gss_div.sv]
// ----------------------------------------------------------------------------
// gss_div
// restoring divider, one quotient bit per cycle, keeps the low step bits
// ----------------------------------------------------------------------------
module gss_div import gss_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [FPS_W-1:0] divisor,
    output div_stat_t        stat
);

    logic                 run_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     num_reg;
    logic [FPS_W-1:0]     den_reg;
    logic [FPS_W-1:0]     rem_reg;
    logic [STEP_W-1:0]    quo_reg;

    logic [FPS_W:0]       trial;
    logic                 ge;
    logic [FPS_W-1:0]     rem_next;

    // shared compare and subtract
    always_comb begin
        trial    = {rem_reg, num_reg[DIV_W-1]};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? FPS_W'(trial - {1'b0, den_reg}) : FPS_W'(trial);
    end

    // iteration control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= DIV_CNT_W'(DIV_W);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath, a zero divisor counts as one
    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= dividend;
            den_reg <= (divisor == '0) ? FPS_W'(1) : divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (run_reg) begin
            num_reg <= {num_reg[DIV_W-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= STEP_W'({quo_reg, ge});
        end
    end

    assign stat.done = done_reg;
    assign stat.quo  = quo_reg;

endmodule

[hw/rtl/gss_cfg.sv]
// ----------------------------------------------------------------------------
// gss_cfg
// register file on the configuration port, holds frames per step
// ----------------------------------------------------------------------------
module gss_cfg import gss_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic [FPS_W-1:0]  fps
);

    logic [FPS_W-1:0]  fps_reg;
    logic [APB_AW-3:0] reg_idx;
    logic              wr_fire;

    assign reg_idx = paddr[APB_AW-1:2];
    assign pready  = 1'b1;
    assign wr_fire = psel && penable && pwrite && pready && (reg_idx == REG_FPS);

    // frames per step register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fps_reg <= FPS_RESET;
        end else if (wr_fire) begin
            fps_reg <= pwdata[FPS_W-1:0];
        end
    end

    // read back
    always_comb begin
        if (reg_idx == REG_FPS) begin
            prdata = {(APB_DW-FPS_W)'(0), fps_reg};
        end else begin
            prdata = '0;
        end
    end

    assign fps = fps_reg;

endmodule

[hw/rtl/grid_step_sequencer_unit.sv]
// tick: the divider runs one iteration per dividend bit, then the column memory is read,
//   loaded and scanned into the output register, one row per cycle up to the highest set
//   row while the output slot is free; the tick ends after the divider when the step is unchanged
// grid release and page move pass through a result state; position, press and refused move
//   do not; items are taken one at a time and a held result stalls the sequencer
// reset (aresetn low at a clock edge) clears the grid through per-column valid bits
// ----------------------------------------------------------------------------
// grid_step_sequencer_unit
// step grid with note-on reporting, paged button editing and frame timing
// ----------------------------------------------------------------------------
module grid_step_sequencer_unit import gss_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    // input beats
    input  logic                s_tvalid,
    output logic                s_tready,
    // pressed[0], button_x[3:1], button_y[6:4], position_frames[38:7], rolling[39]
    input  logic [S_DATA_W-1:0] s_tdata,
    // req_type[1:0]
    input  logic [1:0]          s_tuser,
    // result beats
    output logic                m_tvalid,
    input  logic                m_tready,
    // step_index[3:0], note_number[10:4], cell_value[11], page_col[12], page_row[15:13]
    output logic [M_DATA_W-1:0] m_tdata,
    // out_kind[1:0]
    output logic [1:0]          m_tuser,
    output logic                m_tlast,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    `include "grid_step_sequencer_unit_defines.svh"

    state_t state_reg, state_next;

    logic [FPS_W-1:0]    fps;
    div_stat_t           div_stat;

    logic [FRAME_W-1:0]  frame_cnt_reg;
    logic                rolling_reg;
    logic [STEP_W-1:0]   cur_step_reg;
    logic                page_h_reg;
    logic [2:0]          page_v_reg;
    logic [NUM_STEPS-1:0] col_vld_reg;
    logic                rd_ok_reg;
    logic [NUM_ROWS-1:0] work_reg;
    logic [ROW_W-1:0]    row_cnt_reg;
    logic [STEP_W-1:0]   col_reg;
    logic [ROW_W-1:0]    row_reg;
    out_kind_t           pend_kind_reg;

    logic                m_valid_reg;
    out_kind_t           o_kind_reg;
    logic [STEP_IDX_W-1:0] o_step_reg;
    logic [NOTE_W-1:0]   o_note_reg;
    logic                o_cell_reg;
    logic                o_pcol_reg;
    logic [2:0]          o_prow_reg;
    logic                o_last_reg;

    // input field unpack
    req_type_t           in_req;
    logic                in_pressed;
    logic [2:0]          in_bx;
    logic [2:0]          in_by;
    logic [FRAME_W-1:0]  in_pos;
    logic                in_roll;
    logic                accept;

    assign in_req     = req_type_t'(s_tuser);
    assign in_pressed = s_tdata[0];
    assign in_bx      = s_tdata[3:1];
    assign in_by      = s_tdata[6:4];
    assign in_pos     = s_tdata[38:7];
    assign in_roll    = s_tdata[39];
    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;

    // register file
    gss_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .fps     (fps)
    );

    // divider for the step position
    logic div_start;

    gss_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({frame_cnt_reg, FRAC_W'(0)}),
        .divisor  (fps),
        .stat     (div_stat)
    );

    // paged cell coordinates
    logic [3:0]          col_full;
    logic [5:0]          row_full;
    logic                cell_in_grid;

    assign col_full     = {page_h_reg, in_bx};
    assign row_full     = {page_v_reg, ~in_by};
    assign cell_in_grid = ({1'b0, col_full} < 5'(NUM_STEPS))
                       && ({1'b0, row_full} < 7'(NUM_ROWS));

    // page move decode
    logic                page_ok;
    logic                page_h_new;
    logic [2:0]          page_v_new;

    always_comb begin
        page_ok    = 1'b0;
        page_h_new = page_h_reg;
        page_v_new = page_v_reg;
        case (in_bx)
            PAGE_BTN_VINC: begin
                page_ok    = page_v_reg < PAGE_V_MAX;
                page_v_new = page_v_reg + 3'd1;
            end
            PAGE_BTN_VDEC: begin
                page_ok    = page_v_reg > 3'd0;
                page_v_new = page_v_reg - 3'd1;
            end
            PAGE_BTN_HDEC: begin
                page_ok    = page_h_reg > 1'b0;
                page_h_new = 1'b0;
            end
            PAGE_BTN_HINC: begin
                page_ok    = page_h_reg < PAGE_H_MAX;
                page_h_new = 1'b1;
            end
            default: begin
                page_ok = 1'b0;
            end
        endcase
        page_ok = page_ok && in_pressed;
    end

    // grid column memory
    logic                ram_we;
    logic                ram_re;
    logic [STEP_W-1:0]   ram_raddr;
    logic [NUM_ROWS-1:0] ram_rdata;
    logic [NUM_ROWS-1:0] col_data;
    logic [NUM_ROWS-1:0] toggled;

    gss_ram #(
        .WIDTH (NUM_ROWS),
        .DEPTH (NUM_STEPS)
    ) u_grid (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (col_reg),
        .wdata (toggled),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // a column never written reads as cleared
    assign col_data = rd_ok_reg ? ram_rdata : '0;
    assign toggled  = col_data ^ (NUM_ROWS'(1) << row_reg);

    logic step_changed;
    logic slot_free;
    logic scan_last;

    assign step_changed = div_stat.quo != cur_step_reg;
    assign slot_free    = !m_valid_reg || m_tready;
    assign scan_last    = (work_reg >> 1) == '0;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (in_req)
                        REQ_TICK: state_next = ST_DIV;
                        REQ_GRID: begin
                            if (!in_pressed && cell_in_grid) begin
                                state_next = ST_TOGGLE;
                            end
                        end
                        REQ_PAGE: begin
                            if (page_ok) begin
                                state_next = ST_EMIT;
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = step_changed ? ST_LOAD : ST_IDLE;
                end
            end
            ST_LOAD: begin
                state_next = (col_data == '0) ? ST_EMIT : ST_SCAN;
            end
            ST_SCAN: begin
                if (work_reg[0] && slot_free && scan_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_TOGGLE: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    logic                emit;
    out_kind_t           emit_kind;
    logic [NOTE_W-1:0]   emit_note;
    logic                emit_cell;
    logic                emit_last;
    logic                fire;

    always_comb begin
        emit      = 1'b0;
        emit_kind = KIND_NOTE;
        emit_note = '0;
        emit_cell = 1'b0;
        emit_last = 1'b1;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = STEP_W'(col_full);
        div_start = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                div_start = accept && (in_req == REQ_TICK);
                ram_re    = accept && (in_req == REQ_GRID);
            end
            ST_DIV: begin
                ram_re    = div_stat.done && step_changed;
                ram_raddr = div_stat.quo;
            end
            ST_SCAN: begin
                emit      = work_reg[0];
                emit_kind = KIND_NOTE;
                emit_note = NOTE_BASE + NOTE_W'(row_cnt_reg);
                emit_last = scan_last;
            end
            ST_TOGGLE: begin
                emit      = 1'b1;
                emit_kind = KIND_CELL;
                emit_cell = toggled[row_reg];
                ram_we    = slot_free;
            end
            ST_EMIT: begin
                emit      = 1'b1;
                emit_kind = pend_kind_reg;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    assign fire = emit && slot_free;

    // sequencer state and timing registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            frame_cnt_reg <= '0;
            rolling_reg   <= 1'b0;
            cur_step_reg  <= '0;
            page_h_reg    <= 1'b0;
            page_v_reg    <= 3'd1;
            col_vld_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (accept && (in_req == REQ_POS)) begin
                frame_cnt_reg <= in_pos;
                rolling_reg   <= in_roll;
            end
            if (accept && (in_req == REQ_PAGE) && page_ok) begin
                page_h_reg <= page_h_new;
                page_v_reg <= page_v_new;
            end
            // step update, wrap to zero restarts the frame count
            if ((state_reg == ST_DIV) && div_stat.done) begin
                if (step_changed) begin
                    cur_step_reg <= div_stat.quo;
                end
                if (step_changed && (div_stat.quo == '0)) begin
                    frame_cnt_reg <= FRAME_W'(rolling_reg);
                end else begin
                    frame_cnt_reg <= frame_cnt_reg + FRAME_W'(rolling_reg);
                end
            end
            if (ram_we) begin
                col_vld_reg[col_reg] <= 1'b1;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (ram_re) begin
            rd_ok_reg <= col_vld_reg[ram_raddr];
        end
        if (accept) begin
            col_reg       <= STEP_W'(col_full);
            row_reg       <= ROW_W'(row_full);
            pend_kind_reg <= KIND_PAGE;
        end
        if (state_reg == ST_LOAD) begin
            work_reg      <= col_data;
            row_cnt_reg   <= '0;
            pend_kind_reg <= KIND_STEP;
        end
        // row scan, a set row waits for the output slot
        if ((state_reg == ST_SCAN) && (!work_reg[0] || slot_free)) begin
            work_reg    <= work_reg >> 1;
            row_cnt_reg <= row_cnt_reg + 1'b1;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            o_kind_reg <= emit_kind;
            o_step_reg <= STEP_IDX_W'(cur_step_reg);
            o_note_reg <= emit_note;
            o_cell_reg <= emit_cell;
            o_pcol_reg <= page_h_reg;
            o_prow_reg <= page_v_reg;
            o_last_reg <= emit_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {o_prow_reg, o_pcol_reg, o_cell_reg, o_note_reg, o_step_reg};
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;

    // checks
    `GSS_ASSERT_NXT(a_busy_after_tick, aclk, aresetn,
        s_tvalid && s_tready && (s_tuser == REQ_TICK), !s_tready,
        "input taken while a tick is still being divided")
    `GSS_ASSERT_IMP(a_single_is_last, aclk, aresetn,
        m_tvalid && (m_tuser != KIND_NOTE), m_tlast,
        "non note result not marked last")
    `GSS_ASSERT_IMP(a_note_range, aclk, aresetn,
        m_tvalid && (m_tuser == KIND_NOTE), m_tdata[10:4] >= NOTE_BASE,
        "note-on below the base note")

endmodule
